/* rtl/gnr_pkg.sv */
`timescale 1ns / 1ps
package gnr_pkg;

  localparam int PROB_BITS = 16;
  localparam int PW        = PROB_BITS + 1;
  localparam int Q_BITS    = 16;
  localparam int DIG_BITS  = 4;
  localparam int NODES     = 7;
  localparam int NODE_W    = 3;
  localparam int ROM_W     = 17;
  localparam int ROM_AW    = 6;
  localparam int SHL       = (PROB_BITS >= 16) ? PROB_BITS - 16 : 0;
  localparam int SHR       = (PROB_BITS >= 16) ? 0 : 16 - PROB_BITS;

  localparam logic [PW-1:0]     ONE       = PW'(1) << PROB_BITS;
  localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(NODES);

  localparam logic CFG_MASK   = 1'b0;
  localparam logic CFG_VALUES = 1'b1;

  function automatic logic [ROM_W-1:0] cpt_rom(input logic [ROM_AW-1:0] addr);
    logic [ROM_W-1:0] v;
    case (addr)
      6'd0:  v = 17'd31641;
      6'd1:  v = 17'd32768;
      6'd2:  v = 17'd29786;
      6'd3:  v = 17'd46170;
      6'd4:  v = 17'd32768;
      6'd5:  v = 17'd37939;
      6'd6:  v = 17'd32768;
      6'd7:  v = 17'd28298;
      6'd8:  v = 17'd39669;
      6'd9:  v = 17'd43116;
      6'd10: v = 17'd35750;
      6'd11: v = 17'd46170;
      6'd12: v = 17'd41393;
      6'd13: v = 17'd43116;
      6'd14: v = 17'd29786;
      6'd15: v = 17'd26811;
      6'd16: v = 17'd20696;
      6'd17: v = 17'd29321;
      6'd18: v = 17'd26214;
      6'd19: v = 17'd32768;
      6'd20: v = 17'd21843;
      6'd21: v = 17'd59579;
      6'd22: v = 17'd0;
      6'd23: v = 17'd0;
      6'd24: v = 17'd9365;
      6'd25: v = 17'd10925;
      6'd26: v = 17'd65536;
      6'd27: v = 17'd65536;
      6'd28: v = 17'd65536;
      6'd29: v = 17'd65536;
      6'd30: v = 17'd50410;
      6'd31: v = 17'd65536;
      6'd32: v = 17'd58255;
      6'd33: v = 17'd61165;
      default: v = '0;
    endcase
    return v;
  endfunction

  // conditional probability term of node nd under node vector v
  function automatic logic [PW-1:0] cpt_term(input logic [NODE_W-1:0] nd,
                                             input logic [NODES-1:0] v);
    logic [NODES:0]    vp;
    logic [ROM_AW-1:0] base;
    logic [ROM_AW-1:0] idx;
    logic [ROM_W-1:0]  raw;
    logic [PW-1:0]     p;
    vp = {1'b0, v};
    case (nd)
      3'd0:    base = 6'd0;
      3'd1:    base = 6'd1;
      3'd2:    base = 6'd2;
      3'd3:    base = 6'd6;
      3'd4:    base = 6'd10;
      3'd5:    base = 6'd14;
      3'd6:    base = 6'd18;
      default: base = 6'd0;
    endcase
    if (nd < 3'd2) begin
      idx = '0;
    end else if (nd < 3'd6) begin
      idx = {4'd0, v[0], v[1]};
    end else begin
      idx = {2'd0, v[2], v[3], v[4], v[5]};
    end
    raw = cpt_rom(base + idx);
    if (PROB_BITS >= 16) begin
      p = PW'(raw) << SHL;
    end else begin
      p = PW'(raw >> SHR);
    end
    return vp[nd] ? p : ONE - p;
  endfunction

endpackage

/* rtl/gnr_serial_mul.sv */
`timescale 1ns / 1ps
module gnr_serial_mul import gnr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [PROB_BITS-1:0] a,
  input  logic [PROB_BITS-1:0] b,
  output logic                 done,
  output logic [PROB_BITS-1:0] prod
);

  localparam int NDIG = (PROB_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int DW   = NDIG * DIG_BITS;
  localparam int SW   = PROB_BITS + DIG_BITS;
  localparam int PRW  = PROB_BITS + DW;
  localparam int CW   = $clog2(NDIG + 1);

  logic [PROB_BITS-1:0] a_r, a_nxt;
  logic [DW-1:0]        b_r, b_nxt;
  logic [PRW-1:0]       p_r, p_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SW-1:0]        pp;
  logic [SW-1:0]        s;

  assign pp = SW'(a_r) * SW'(b_r[DIG_BITS-1:0]);
  assign s  = SW'(p_r[PRW-1:DW]) + pp;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = DW'(b);
      p_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // add one digit's partial product, shift right one digit
      p_nxt   = {s, p_r[DW-1:DIG_BITS]};
      b_nxt   = {DIG_BITS'(0), b_r[DW-1:DIG_BITS]};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NDIG - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r[2*PROB_BITS-1:PROB_BITS];

endmodule

/* rtl/gnr_serial_div.sv */
`timescale 1ns / 1ps
module gnr_serial_div import gnr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PW-1:0]     num,
  input  logic [PW:0]       den,
  output logic              done,
  output logic [Q_BITS-1:0] quot
);

  localparam int CW = $clog2(Q_BITS + 1);

  logic [PW:0]       r_r, r_nxt;
  logic [PW:0]       d_r, d_nxt;
  logic [Q_BITS-1:0] q_r, q_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PW+1:0]     r_sh;
  logic [PW+1:0]     r_sub;
  logic              fits;

  assign r_sh  = {r_r, 1'b0};
  assign fits  = r_sh >= {1'b0, d_r};
  assign r_sub = r_sh - {1'b0, d_r};

  always_comb begin
    r_nxt    = r_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      r_nxt    = {1'b0, num};
      d_nxt    = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one restoring step per cycle
      r_nxt   = fits ? r_sub[PW:0] : r_sh[PW:0];
      q_nxt   = {q_r[Q_BITS-2:0], fits};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(Q_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/gibbs_node_resampler_top.sv */
// An observed node or node index seven goes straight to the result; otherwise a root takes
// longest from request accept to result valid, then a middle node, then the sink.
// Products run on the 4-bit-per-cycle multiplier (bypassed when a factor is one); the
// 16-step divider sits between a setup state and the result load.
// One request is handled at a time, the next accepted the cycle after the result
// loads. Reset (sync, active low): nodes all ones, mask 0, values 127.
`timescale 1ns / 1ps
module gibbs_node_resampler_top import gnr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [NODES-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [NODE_W-1:0] in_node_index,
  input  logic [15:0]       in_random_draw,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_new_value,
  output logic [NODES-1:0]  out_state_vector,
  output logic [15:0]       out_prob_true,
  output logic              out_was_observed
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TERM = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DSET = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [Q_BITS:0] Q_HALF = (Q_BITS + 1)'(1) << (Q_BITS - 1);
  localparam logic [Q_BITS:0] Q_ONE  = (Q_BITS + 1)'(1) << Q_BITS;

  logic [2:0]        state_r, state_nxt;
  logic [NODES-1:0]  mask_r, mask_nxt;
  logic [NODES-1:0]  values_r, values_nxt;
  logic [NODES-1:0]  nodes_r, nodes_nxt;
  logic [NODE_W-1:0] n_r, n_nxt;
  logic [15:0]       draw_r, draw_nxt;
  logic [NODES-1:0]  eff_r, eff_nxt;
  logic              hyp_r, hyp_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [PW-1:0]     p1_r, p1_nxt;
  logic [PW-1:0]     p0_r, p0_nxt;
  logic [Q_BITS:0]   q_r, q_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_nv_r, out_nv_nxt;
  logic [NODES-1:0]  out_sv_r, out_sv_nxt;
  logic [15:0]       out_prob_r, out_prob_nxt;
  logic              out_obs_r, out_obs_nxt;

  logic [NODES:0]    mask_pad;
  logic [NODES:0]    eff_pad;
  logic [NODES:0]    sel_pad;
  logic [NODES-1:0]  sel;
  logic [NODES-1:0]  vh;
  logic [NODE_W-1:0] cur_node;
  logic [2:0]        last_step;
  logic [PW-1:0]     term_v;
  logic [PW:0]       sum;
  logic              adv;
  logic [PW-1:0]     adv_val;
  logic              mul_start;
  logic              mul_done;
  logic [PROB_BITS-1:0] mul_prod;
  logic              div_start;
  logic              div_done;
  logic [Q_BITS-1:0] div_quot;
  logic              obs;
  logic              nv;

  assign mask_pad = {1'b0, mask_r};
  assign eff_pad  = {1'b0, eff_r};
  assign sel_pad  = (NODES + 1)'(1) << n_r;
  assign sel      = sel_pad[NODES-1:0];
  assign vh       = hyp_r ? (eff_r | sel) : (eff_r & ~sel);

  always_comb begin
    if (step_r == 3'd0) begin
      cur_node = n_r;
    end else if (n_r < 3'd2) begin
      cur_node = 3'd6 - step_r;
    end else begin
      cur_node = 3'd6;
    end
    if (n_r < 3'd2) begin
      last_step = 3'd4;
    end else if (n_r < 3'd6) begin
      last_step = 3'd1;
    end else begin
      last_step = 3'd0;
    end
  end

  assign term_v = cpt_term(cur_node, vh);
  assign sum    = {1'b0, p1_r} + {1'b0, p0_r};
  assign obs    = (n_r != NODE_NONE) && mask_pad[n_r];
  assign nv     = {1'b0, draw_r} < q_r;

  gnr_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (acc_r[PROB_BITS-1:0]),
    .b     (term_v[PROB_BITS-1:0]),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gnr_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p1_r),
    .den   (sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    values_nxt    = values_r;
    nodes_nxt     = nodes_r;
    n_nxt         = n_r;
    draw_nxt      = draw_r;
    eff_nxt       = eff_r;
    hyp_nxt       = hyp_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    p1_nxt        = p1_r;
    p0_nxt        = p0_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nv_nxt    = out_nv_r;
    out_sv_nxt    = out_sv_r;
    out_prob_nxt  = out_prob_r;
    out_obs_nxt   = out_obs_r;
    adv           = 1'b0;
    adv_val       = acc_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MASK:   mask_nxt = cfg_wdata;
        CFG_VALUES: values_nxt = cfg_wdata;
        default:    mask_nxt = mask_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_node_index;
          draw_nxt = in_random_draw;
          eff_nxt  = (nodes_r & ~mask_r) | (values_r & mask_r);
          hyp_nxt  = 1'b1;
          step_nxt = '0;
          if (in_node_index == NODE_NONE || mask_pad[in_node_index]) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (step_r == 3'd0 || acc_r == ONE) begin
          adv     = 1'b1;
          adv_val = term_v;
        end else if (term_v == ONE) begin
          adv     = 1'b1;
          adv_val = acc_r;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          adv     = 1'b1;
          adv_val = {1'b0, mul_prod};
        end
      end
      S_DSET: begin
        if (sum == '0) begin
          q_nxt     = Q_HALF;
          state_nxt = S_DONE;
        end else if (p0_r == '0) begin
          q_nxt     = Q_ONE;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = {1'b0, div_quot};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (n_r == NODE_NONE) begin
            out_nv_nxt   = 1'b0;
            out_prob_nxt = '0;
            out_obs_nxt  = 1'b0;
            out_sv_nxt   = eff_r;
          end else if (obs) begin
            out_nv_nxt   = eff_pad[n_r];
            out_prob_nxt = '0;
            out_obs_nxt  = 1'b1;
            out_sv_nxt   = eff_r;
          end else begin
            out_nv_nxt   = nv;
            out_prob_nxt = q_r[Q_BITS] ? '1 : q_r[Q_BITS-1:0];
            out_obs_nxt  = 1'b0;
            out_sv_nxt   = (eff_r & ~sel) | (nv ? sel : '0);
          end
          nodes_nxt = out_sv_nxt;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance the product chain of the current hypothesis
    if (adv) begin
      if (step_r == last_step) begin
        if (hyp_r) begin
          p1_nxt    = adv_val;
          hyp_nxt   = 1'b0;
          step_nxt  = '0;
          state_nxt = S_TERM;
        end else begin
          p0_nxt    = adv_val;
          state_nxt = S_DSET;
        end
      end else begin
        acc_nxt   = adv_val;
        step_nxt  = step_r + 3'd1;
        state_nxt = S_TERM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      values_r    <= '1;
      nodes_r     <= '1;
      out_valid_r <= 1'b0;
      hyp_r       <= 1'b1;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      values_r    <= values_nxt;
      nodes_r     <= nodes_nxt;
      out_valid_r <= out_valid_nxt;
      hyp_r       <= hyp_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    draw_r     <= draw_nxt;
    eff_r      <= eff_nxt;
    acc_r      <= acc_nxt;
    p1_r       <= p1_nxt;
    p0_r       <= p0_nxt;
    q_r        <= q_nxt;
    out_nv_r   <= out_nv_nxt;
    out_sv_r   <= out_sv_nxt;
    out_prob_r <= out_prob_nxt;
    out_obs_r  <= out_obs_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_new_value    = out_nv_r;
  assign out_state_vector = out_sv_r;
  assign out_prob_true    = out_prob_r;
  assign out_was_observed = out_obs_r;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench import gnr_pkg::*;;

  localparam int   WATCHDOG_LIMIT      = 3000;
  localparam int   DRAIN_CYCLES        = 80;
  localparam int   RANDOM_PHASES       = 12;
  localparam int   REQUESTS_PER_PHASE  = 100;
  localparam int   HOLD_AFTER          = 300;
  localparam int   HOLD_CYCLES         = 600;
  localparam longint unsigned UNIT     = 64'd1 << PROB_BITS;

  localparam int unsigned CPT_Q16 [34] = '{
    31641, 32768,
    29786, 46170, 32768, 37939,
    32768, 28298, 39669, 43116,
    35750, 46170, 41393, 43116,
    29786, 26811, 20696, 29321,
    26214, 32768, 21843, 59579, 0, 0, 9365, 10925,
    65536, 65536, 65536, 65536, 50410, 65536, 58255, 61165
  };
  localparam int unsigned CPT_OFS [7] = '{0, 1, 2, 6, 10, 14, 18};

  typedef struct packed {
    logic              new_value;
    logic [NODES-1:0]  state_vector;
    logic [15:0]       prob_true;
    logic              was_observed;
  } resample_t;

  typedef struct packed {
    logic [NODES-1:0]  mask;
    logic [NODES-1:0]  vals;
    logic [NODE_W-1:0] node;
    logic [15:0]       draw;
    logic              typed;
    resample_t         result;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic [NODES-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [NODE_W-1:0] in_node_index;
  logic [15:0]       in_random_draw;
  logic              out_valid;
  logic              out_stall;
  logic              out_new_value;
  logic [NODES-1:0]  out_state_vector;
  logic [15:0]       out_prob_true;
  logic              out_was_observed;

  logic [NODES-1:0]  model_nodes;
  logic [NODES-1:0]  ev_mask;
  logic [NODES-1:0]  ev_vals;
  resample_t         expected_q [$];

  int mismatches = 0;
  int burst_left = 0;
  int sampled_cnt = 0;
  int observed_cnt = 0;
  int no_node_cnt = 0;
  int settings_cnt = 0;
  int quiet_cycles = 0;
  int stall_mode;
  int stall_left;
  int hold_left;
  int seen_requests;
  bit hold_done;

  dir_row_t directed_rows [22] = '{
    '{7'h00, 7'h7F, NODE_NONE, 16'h0000, 1'b1, '{1'b0, 7'h7F, 16'h0000, 1'b0}},
    '{7'h00, 7'h7F, 3'd0, 16'h0000, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd1, 16'hFFFF, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd2, 16'h5555, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd3, 16'hAAAA, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd4, 16'h0000, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd5, 16'hFFFF, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd6, 16'h8000, 1'b0, '0},
    '{7'h7F, 7'h00, 3'd0, 16'h0000, 1'b1, '{1'b0, 7'h00, 16'h0000, 1'b1}},
    '{7'h7F, 7'h7F, 3'd6, 16'hFFFF, 1'b1, '{1'b1, 7'h7F, 16'h0000, 1'b1}},
    '{7'h7F, 7'h55, NODE_NONE, 16'hFFFF, 1'b1, '{1'b0, 7'h55, 16'h0000, 1'b0}},
    '{7'h7F, 7'h2A, 3'd3, 16'h1234, 1'b1, '{1'b1, 7'h2A, 16'h0000, 1'b1}},
    '{7'h3F, 7'h04, 3'd6, 16'hFFFF, 1'b1, '{1'b1, 7'h44, 16'hFFFF, 1'b0}},
    '{7'h3F, 7'h04, 3'd6, 16'h0000, 1'b1, '{1'b1, 7'h44, 16'hFFFF, 1'b0}},
    '{7'h3F, 7'h08, 3'd6, 16'h0000, 1'b1, '{1'b0, 7'h08, 16'h0000, 1'b0}},
    '{7'h5F, 7'h48, 3'd5, 16'h7FFF, 1'b1, '{1'b1, 7'h68, 16'h8000, 1'b0}},
    '{7'h5F, 7'h48, 3'd5, 16'h8000, 1'b1, '{1'b0, 7'h48, 16'h8000, 1'b0}},
    '{7'h00, 7'h7F, 3'd2, 16'h0000, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd0, 16'hFFFF, 1'b0, '0},
    '{7'h00, 7'h7F, 3'd1, 16'h0001, 1'b0, '0},
    '{7'h01, 7'h00, 3'd4, 16'h8000, 1'b0, '0},
    '{7'h01, 7'h00, 3'd0, 16'h4000, 1'b0, '0}
  };

  gibbs_node_resampler_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_node_index    (in_node_index),
    .in_random_draw   (in_random_draw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_state_vector (out_state_vector),
    .out_prob_true    (out_prob_true),
    .out_was_observed (out_was_observed)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned cond_prob(input int n, input logic [NODES-1:0] v);
    int idx;
    longint unsigned p;
    if (n < 2) begin
      idx = 0;
    end else if (n < 6) begin
      idx = {v[0], v[1]};
    end else begin
      idx = {v[2], v[3], v[4], v[5]};
    end
    p = (longint'(CPT_Q16[CPT_OFS[n] + idx]) << SHL) >> SHR;
    return v[n] ? p : UNIT - p;
  endfunction

  function automatic longint unsigned fixed_mul(input longint unsigned a,
                                                input longint unsigned b);
    if (a == UNIT) return b;
    if (b == UNIT) return a;
    return (a * b) >> PROB_BITS;
  endfunction

  function automatic longint unsigned blanket_weight(input int n, input logic [NODES-1:0] v);
    longint unsigned acc;
    acc = cond_prob(n, v);
    if (n < 2) begin
      for (int c = 5; c >= 2; c--) acc = fixed_mul(acc, cond_prob(c, v));
    end else if (n < 6) begin
      acc = fixed_mul(acc, cond_prob(6, v));
    end
    return acc;
  endfunction

  function automatic resample_t resample(input logic [NODE_W-1:0] node,
                                         input logic [15:0] draw);
    logic [NODES-1:0] eff;
    longint unsigned  p1;
    longint unsigned  p0;
    longint unsigned  q;
    resample_t        r;
    eff = (model_nodes & ~ev_mask) | (ev_vals & ev_mask);
    r = '0;
    if (node < NODES && ev_mask[node]) begin
      r.was_observed = 1'b1;
      r.new_value = eff[node];
    end else if (node < NODES) begin
      p1 = blanket_weight(node, eff | (NODES'(1) << node));
      p0 = blanket_weight(node, eff & ~(NODES'(1) << node));
      q = (p1 + p0 == 0) ? 64'd32768 : (p1 << 16) / (p1 + p0);
      r.new_value = (64'(draw) < q);
      r.prob_true = (q > 65535) ? 16'hFFFF : q[15:0];
      eff[node] = r.new_value;
    end
    model_nodes = eff;
    r.state_vector = eff;
    return r;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_evidence(input logic [NODES-1:0] mask, input logic [NODES-1:0] vals);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_VALUES;
    cfg_wdata <= vals;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ev_mask = mask;
    ev_vals = vals;
    settings_cnt++;
  endtask

  task automatic offer(input logic [NODE_W-1:0] node, input logic [15:0] draw,
                       input logic typed, input resample_t typed_res);
    int        gap;
    resample_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_node_index <= node;
    in_random_draw <= draw;
    do @(posedge clk); while (in_stall);
    if (node >= NODES) no_node_cnt++;
    else if (ev_mask[node]) observed_cnt++;
    else sampled_cnt++;
    r = resample(node, draw);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  always @(posedge clk) begin
    resample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: state_vector %h", out_state_vector);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_new_value !== want.new_value) begin
          $error("new_value: expected %0d, got %0d", want.new_value, out_new_value);
          mismatches++;
        end
        if (out_state_vector !== want.state_vector) begin
          $error("state_vector: expected %h, got %h", want.state_vector, out_state_vector);
          mismatches++;
        end
        if (out_prob_true !== want.prob_true) begin
          $error("prob_true: expected %0d, got %0d", want.prob_true, out_prob_true);
          mismatches++;
        end
        if (out_was_observed !== want.was_observed) begin
          $error("was_observed: expected %0d, got %0d", want.was_observed, out_was_observed);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      seen_requests <= 0;
    end else begin
      if (in_valid && !in_stall) seen_requests <= seen_requests + 1;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && seen_requests >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          stall_left <= $urandom_range(16, 160);
        end else begin
          stall_left <= stall_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_left[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: timeout with %0d results outstanding", expected_q.size());
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [NODE_W-1:0] node;
    logic [15:0]       draw;
    logic [NODES-1:0]  mask;
    logic [NODES-1:0]  vals;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_MASK;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_node_index <= '0;
    in_random_draw <= '0;
    model_nodes = '1;
    ev_mask = '0;
    ev_vals = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mask != ev_mask || directed_rows[i].vals != ev_vals)
        set_evidence(directed_rows[i].mask, directed_rows[i].vals);
      offer(directed_rows[i].node, directed_rows[i].draw, directed_rows[i].typed,
            directed_rows[i].result);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mask = (phase == 0) ? '0 : (phase == 1) ? '1 :
             NODES'($urandom_range(0, 127) & $urandom_range(0, 127));
      vals = (phase == 2) ? '0 : (phase == 3) ? '1 : NODES'($urandom_range(0, 127));
      set_evidence(mask, vals);
      repeat (REQUESTS_PER_PHASE) begin
        node = ($urandom_range(0, 11) == 0) ? NODE_NONE : NODE_W'($urandom_range(0, 6));
        case ($urandom_range(0, 9))
          0: draw = 16'h0000;
          1: draw = 16'hFFFF;
          default: draw = 16'($urandom_range(0, 65535));
        endcase
        offer(node, draw, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("testbench: %0d sampled, %0d evidence and %0d no-node requests",
             sampled_cnt, observed_cnt, no_node_cnt);
    $display("testbench: %0d evidence settings, %0d field mismatches",
             settings_cnt, mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* gibbs_node_resampler_top.f */
rtl/gnr_pkg.sv
rtl/gnr_serial_mul.sv
rtl/gnr_serial_div.sv
rtl/gibbs_node_resampler_top.sv
test/testbench.sv
